### rtl/ipc_pkg.sv
// Package for the irrigation pump controller: types, register indexes and reset values.
`timescale 1ns / 1ps
package ipc_pkg;

  // Field widths
  localparam int unsigned TEMP_W   = 8;
  localparam int unsigned HUM_W    = 8;
  localparam int unsigned SOIL_W   = 7;
  localparam int unsigned SECS_W   = 16;
  localparam int unsigned FLOW_W   = 8;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned WATER_W  = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;

  // Register reset values
  localparam logic [TEMP_W-1:0] TEMP_THR_RST     = 8'd30;
  localparam logic [HUM_W-1:0]  HUM_THR_RST      = 8'd20;
  localparam logic [SOIL_W-1:0] MOIST_THR_RST    = 7'd35;
  localparam logic [SECS_W-1:0] MIN_RUN_RST      = 16'd10;
  localparam logic [SECS_W-1:0] MAX_RUN_RST      = 16'd20;
  localparam logic [SECS_W-1:0] REST_RST         = 16'd60;
  localparam logic [FLOW_W-1:0] FLOW_RST         = 8'd1;

  // Item kinds
  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_THR  = 3'd0,
    REG_HUM_THR   = 3'd1,
    REG_MOIST_THR = 3'd2,
    REG_MIN_RUN   = 3'd3,
    REG_MAX_RUN   = 3'd4,
    REG_REST      = 3'd5,
    REG_FLOW      = 3'd6
  } ipc_reg_idx_t;

  typedef struct packed {
    logic [TEMP_W-1:0] temp_threshold;
    logic [HUM_W-1:0]  humidity_threshold;
    logic [SOIL_W-1:0] moisture_threshold;
    logic [SECS_W-1:0] min_run_seconds;
    logic [SECS_W-1:0] max_run_seconds;
    logic [SECS_W-1:0] rest_seconds;
    logic [FLOW_W-1:0] flow_per_second;
  } ipc_cfg_t;

  typedef struct packed {
    logic              kind;
    logic [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]  humidity;
    logic [SOIL_W-1:0] soil_level;
    logic              manual;
  } ipc_item_t;

  typedef struct packed {
    logic               timer_active;
    logic [SECS_W-1:0]  elapsed_seconds;
    logic               motor_running;
    logic               rest_flag;
    logic               minimum_pending;
    logic               limit_reached;
    logic [TOTAL_W-1:0] total_seconds;
  } ipc_state_t;

  // Snapshot handed from the state update to the water stage
  typedef struct packed {
    logic               pump_on;
    logic               resting;
    logic [TOTAL_W:0]   secs;
  } ipc_snap_t;

  typedef struct packed {
    logic               pump_on;
    logic               resting;
    logic [WATER_W-1:0] water_used;
  } ipc_result_t;

endpackage

### rtl/ipc_regs.sv
// Configuration register file of the irrigation pump controller.
`timescale 1ns / 1ps
module ipc_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [ipc_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [ipc_pkg::CFG_DATA_W-1:0] wr_data,
  output ipc_pkg::ipc_cfg_t              cfg
);
  import ipc_pkg::*;

  // Write one register per transaction; indexes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_threshold     <= TEMP_THR_RST;
      cfg.humidity_threshold <= HUM_THR_RST;
      cfg.moisture_threshold <= MOIST_THR_RST;
      cfg.min_run_seconds    <= MIN_RUN_RST;
      cfg.max_run_seconds    <= MAX_RUN_RST;
      cfg.rest_seconds       <= REST_RST;
      cfg.flow_per_second    <= FLOW_RST;
    end else if (wr_en) begin
      case (ipc_reg_idx_t'(wr_index))
        REG_TEMP_THR:  cfg.temp_threshold     <= wr_data[TEMP_W-1:0];
        REG_HUM_THR:   cfg.humidity_threshold <= wr_data[HUM_W-1:0];
        REG_MOIST_THR: cfg.moisture_threshold <= wr_data[SOIL_W-1:0];
        REG_MIN_RUN:   cfg.min_run_seconds    <= wr_data[SECS_W-1:0];
        REG_MAX_RUN:   cfg.max_run_seconds    <= wr_data[SECS_W-1:0];
        REG_REST:      cfg.rest_seconds       <= wr_data[SECS_W-1:0];
        REG_FLOW:      cfg.flow_per_second    <= wr_data[FLOW_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

### rtl/ipc_core.sv
// Pump state update: timer, run and rest flags, total pumped seconds.
`timescale 1ns / 1ps
module ipc_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  ipc_pkg::ipc_item_t  item,
  input  ipc_pkg::ipc_cfg_t   cfg,
  output ipc_pkg::ipc_state_t state,
  output ipc_pkg::ipc_snap_t  snap
);
  import ipc_pkg::*;

  ipc_state_t state_next;
  logic [SECS_W-1:0] elapsed_inc;
  logic [TOTAL_W:0]  total_sum;
  logic [TOTAL_W-1:0] total_sat;
  logic need;
  logic pending_eff;
  logic limit_eff;
  logic [TOTAL_W:0] secs_next;

  // Saturating timer increment and run total
  assign elapsed_inc = (state.elapsed_seconds == {SECS_W{1'b1}}) ?
                       state.elapsed_seconds : state.elapsed_seconds + 1'b1;
  assign total_sum = {1'b0, state.total_seconds} +
                     {{(TOTAL_W + 1 - SECS_W){1'b0}}, state.elapsed_seconds};
  assign total_sat = total_sum[TOTAL_W] ? {TOTAL_W{1'b1}} : total_sum[TOTAL_W-1:0];

  // Water demand and the flags as a fresh evaluation sees them
  assign need = (item.temperature > cfg.temp_threshold) ||
                (item.humidity < cfg.humidity_threshold) ||
                (item.soil_level < cfg.moisture_threshold);
  assign pending_eff = state.timer_active ? state.minimum_pending : 1'b1;
  assign limit_eff   = state.timer_active ? state.limit_reached : 1'b0;

  // Next state for the item in the input register
  always_comb begin
    state_next = state;
    if (item.kind == KIND_TICK) begin
      if (state.timer_active) begin
        state_next.elapsed_seconds = elapsed_inc;
        if (state.motor_running) begin
          if (elapsed_inc > cfg.min_run_seconds) state_next.minimum_pending = 1'b0;
          if (elapsed_inc > cfg.max_run_seconds) state_next.limit_reached = 1'b1;
        end else if (elapsed_inc >= cfg.rest_seconds) begin
          state_next.timer_active    = 1'b0;
          state_next.elapsed_seconds = '0;
          state_next.rest_flag       = 1'b0;
        end
      end
    end else if (item.manual) begin
      // Manual stop: book the run and drop the timer
      if (state.motor_running) begin
        state_next.total_seconds   = total_sat;
        state_next.elapsed_seconds = '0;
        state_next.timer_active    = 1'b0;
      end
      state_next.rest_flag     = 1'b0;
      state_next.motor_running = 1'b0;
    end else begin
      state_next.minimum_pending = pending_eff;
      state_next.limit_reached   = limit_eff;
      if (state.rest_flag) begin
        state_next.motor_running = 1'b0;
      end else if (state.motor_running && pending_eff) begin
        state_next.motor_running = 1'b1;
      end else if (need && !limit_eff) begin
        state_next.motor_running = 1'b1;
        if (!state.timer_active) begin
          state_next.timer_active    = 1'b1;
          state_next.elapsed_seconds = '0;
        end
      end else if (state.motor_running) begin
        // Automatic stop: book the run and start the rest interval
        state_next.total_seconds   = total_sat;
        state_next.motor_running   = 1'b0;
        state_next.elapsed_seconds = '0;
        state_next.rest_flag       = 1'b1;
      end
    end
  end

  // Seconds counted toward water use after this item
  assign secs_next = {1'b0, state_next.total_seconds} +
                     (state_next.motor_running ?
                      {{(TOTAL_W + 1 - SECS_W){1'b0}}, state_next.elapsed_seconds} :
                      {(TOTAL_W + 1){1'b0}});

  // Advance the state and capture the snapshot
  always_ff @(posedge clk) begin
    if (rst) begin
      state.timer_active    <= 1'b0;
      state.elapsed_seconds <= '0;
      state.motor_running   <= 1'b0;
      state.rest_flag       <= 1'b0;
      state.minimum_pending <= 1'b1;
      state.limit_reached   <= 1'b0;
      state.total_seconds   <= '0;
    end else if (step) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      snap.pump_on <= state_next.motor_running;
      snap.resting <= state_next.rest_flag;
      snap.secs    <= secs_next;
    end
  end

endmodule

### rtl/ipc_water.sv
// Water use stage: flow times pumped seconds, saturated, into the result register.
`timescale 1ns / 1ps
module ipc_water (
  input  logic                             clk,
  input  logic                             load,
  input  ipc_pkg::ipc_snap_t               snap,
  input  logic [ipc_pkg::FLOW_W-1:0]       flow,
  output ipc_pkg::ipc_result_t             result
);
  import ipc_pkg::*;

  localparam int unsigned PROD_W = TOTAL_W + 1 + FLOW_W;

  logic [PROD_W-1:0]  product;
  logic [WATER_W-1:0] water_sat;

  // Multiply and clamp to the output width
  assign product   = PROD_W'(snap.secs) * PROD_W'(flow);
  assign water_sat = (|product[PROD_W-1:WATER_W]) ? {WATER_W{1'b1}} :
                     product[WATER_W-1:0];

  // Hold the result until the next load
  always_ff @(posedge clk) begin
    if (load) begin
      result.pump_on    <= snap.pump_on;
      result.resting    <= snap.resting;
      result.water_used <= water_sat;
    end
  end

endmodule

### rtl/irrigation_pump_controller.sv
// Top level of the irrigation pump controller: stream ports, pipeline control, checks.
`timescale 1ns / 1ps
// Each transaction on the slave side is a one-second tick (tuser 0) or a sensor
// evaluation (tuser 1) and yields exactly one result on the master side, in order.
// A new transaction is taken every cycle unless back pressure holds the input register;
// its result passes the input register, then the combinational state update into the
// snapshot register, then multiply-and-saturate into the result register, and back
// pressure on the master side stalls the stages in turn. The state update takes a new
// item whenever the snapshot stage can accept it, which sets the rate of one item per clock.
// Configuration writes are taken every cycle and should be issued while no
// transaction is in flight; indexes past the last register are ignored.
module irrigation_pump_controller (
  input  logic                           clk,
  input  logic                           rst,
  // slave stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: temperature[7:0], humidity[15:8], soil_level[22:16], manual[23]
  input  logic [ipc_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // tuser: kind[0]
  input  logic                           s_axis_tuser,
  // master stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: pump_on[0], resting[1], water_used[33:2], zero fill[39:34]
  output logic [ipc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ipc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ipc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import ipc_pkg::*;

  ipc_cfg_t    cfg;
  ipc_item_t   item;
  ipc_state_t  state;
  ipc_snap_t   snap;
  ipc_result_t result;

  logic in_valid;
  logic snap_valid;
  logic out_valid;
  logic out_ready;
  logic snap_ready;
  logic in_ready;
  logic step;
  logic load_out;

  assign cfg_ready = 1'b1;

  ipc_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Stage readiness, back to front
  assign out_ready  = !out_valid || m_axis_tready;
  assign snap_ready = !snap_valid || out_ready;
  assign in_ready   = !in_valid || snap_ready;
  assign step       = in_valid && snap_ready;
  assign load_out   = snap_valid && out_ready;

  assign s_axis_tready = in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      snap_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready)   in_valid   <= s_axis_tvalid;
      if (snap_ready) snap_valid <= in_valid;
      if (out_ready)  out_valid  <= snap_valid;
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && in_ready) begin
      item.kind        <= s_axis_tuser;
      item.temperature <= s_axis_tdata[7:0];
      item.humidity    <= s_axis_tdata[15:8];
      item.soil_level  <= s_axis_tdata[22:16];
      item.manual      <= s_axis_tdata[23];
    end
  end

  ipc_core u_core (
    .clk   (clk),
    .rst   (rst),
    .step  (step),
    .item  (item),
    .cfg   (cfg),
    .state (state),
    .snap  (snap)
  );

  ipc_water u_water (
    .clk    (clk),
    .load   (load_out),
    .snap   (snap),
    .flow   (cfg.flow_per_second),
    .result (result)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_DATA_W - WATER_W - 2){1'b0}}, result.water_used,
                          result.resting, result.pump_on};

  // Pump and rest interval never coincide in a delivered result
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("pump_on and resting both set in a result");

  // A running pump always has its timer active
  assert property (@(posedge clk) disable iff (rst)
    state.motor_running |-> state.timer_active)
    else $error("pump running without active timer");

  // A rest interval is timed by an active timer
  assert property (@(posedge clk) disable iff (rst)
    state.rest_flag |-> state.timer_active)
    else $error("rest flag set without active timer");

  // An idle timer holds zero elapsed seconds
  assert property (@(posedge clk) disable iff (rst)
    !state.timer_active |-> (state.elapsed_seconds == '0))
    else $error("elapsed seconds nonzero with timer inactive");

endmodule

### sim/tb_top.sv
// Testbench for the irrigation pump controller: directed table, random phases, scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import ipc_pkg::*;

  localparam int unsigned DRAIN_CYCLES   = 8;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS    = 64;
  localparam int unsigned PHASE_ITEMS    = 75;
  localparam int unsigned NUM_PHASES     = 6;
  // index past the last register; the block must drop writes to it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  // one row of the directed table: a register write or an item
  typedef struct {
    bit                    is_cfg;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    ipc_item_t             item;
    bit                    typed;
    ipc_result_t           want;
  } plan_row_t;

  ipc_cfg_t    reg_shadow;
  ipc_state_t  pump_state;
  ipc_result_t reports_due[$];
  plan_row_t   plan[$];

  int unsigned err_count   = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_left  = 0;
  bit          idle_on     = 1'b1;

  irrigation_pump_controller uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Add a finished run to the pumped total, saturating
  function automatic logic [TOTAL_W-1:0] add_run_time(input logic [TOTAL_W-1:0] total,
                                                      input logic [SECS_W-1:0] secs);
    logic [TOTAL_W:0] sum;
    sum = total + secs;
    return sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
  endfunction

  // Advance the pump state by one item and return the report it produces
  function automatic ipc_result_t predict_report(input ipc_item_t it);
    logic                      need;
    logic [TOTAL_W:0]          secs;
    logic [TOTAL_W+FLOW_W:0]   water;
    ipc_result_t               r;
    if (it.kind == KIND_TICK) begin
      if (pump_state.timer_active) begin
        if (pump_state.elapsed_seconds != '1)
          pump_state.elapsed_seconds = pump_state.elapsed_seconds + 1'b1;
        if (pump_state.motor_running) begin
          if (pump_state.elapsed_seconds > reg_shadow.min_run_seconds)
            pump_state.minimum_pending = 1'b0;
          if (pump_state.elapsed_seconds > reg_shadow.max_run_seconds)
            pump_state.limit_reached = 1'b1;
        end else if (pump_state.elapsed_seconds >= reg_shadow.rest_seconds) begin
          pump_state.timer_active    = 1'b0;
          pump_state.elapsed_seconds = '0;
          pump_state.rest_flag       = 1'b0;
        end
      end
    end else if (it.manual) begin
      // manual stop books the run and kills the timer
      if (pump_state.motor_running) begin
        pump_state.total_seconds   = add_run_time(pump_state.total_seconds,
                                                  pump_state.elapsed_seconds);
        pump_state.elapsed_seconds = '0;
        pump_state.timer_active    = 1'b0;
      end
      pump_state.rest_flag     = 1'b0;
      pump_state.motor_running = 1'b0;
    end else begin
      need = (it.temperature > reg_shadow.temp_threshold) ||
             (it.humidity < reg_shadow.humidity_threshold) ||
             (it.soil_level < reg_shadow.moisture_threshold);
      if (!pump_state.timer_active) begin
        pump_state.limit_reached   = 1'b0;
        pump_state.minimum_pending = 1'b1;
      end
      if (pump_state.rest_flag) begin
        pump_state.motor_running = 1'b0;
      end else if (pump_state.motor_running && pump_state.minimum_pending) begin
        // hold the pump on until the minimum time is met
      end else if (need && !pump_state.limit_reached) begin
        pump_state.motor_running = 1'b1;
        if (!pump_state.timer_active) begin
          pump_state.timer_active    = 1'b1;
          pump_state.elapsed_seconds = '0;
        end
      end else if (pump_state.motor_running) begin
        pump_state.total_seconds   = add_run_time(pump_state.total_seconds,
                                                  pump_state.elapsed_seconds);
        pump_state.motor_running   = 1'b0;
        pump_state.elapsed_seconds = '0;
        pump_state.rest_flag       = 1'b1;
      end
    end
    // water counts the current run only while the pump drives
    secs = pump_state.total_seconds;
    if (pump_state.motor_running)
      secs = secs + pump_state.elapsed_seconds;
    water = secs * reg_shadow.flow_per_second;
    r.pump_on    = pump_state.motor_running;
    r.resting    = pump_state.rest_flag;
    r.water_used = (water > 32'hFFFF_FFFF) ? '1 : water[WATER_W-1:0];
    return r;
  endfunction

  function automatic ipc_item_t make_item(input logic kind, input logic [TEMP_W-1:0] t,
                                          input logic [HUM_W-1:0] h,
                                          input logic [SOIL_W-1:0] s, input logic m);
    ipc_item_t it;
    it.kind        = kind;
    it.temperature = t;
    it.humidity    = h;
    it.soil_level  = s;
    it.manual      = m;
    return it;
  endfunction

  function automatic plan_row_t item_row(input logic kind, input logic [TEMP_W-1:0] t,
                                         input logic [HUM_W-1:0] h,
                                         input logic [SOIL_W-1:0] s, input logic m);
    plan_row_t r;
    r.is_cfg = 1'b0;
    r.idx    = '0;
    r.val    = '0;
    r.item   = make_item(kind, t, h, s, m);
    r.typed  = 1'b0;
    r.want   = '0;
    return r;
  endfunction

  function automatic plan_row_t typed_row(input logic kind, input logic [TEMP_W-1:0] t,
                                          input logic [HUM_W-1:0] h,
                                          input logic [SOIL_W-1:0] s, input logic m,
                                          input logic pump, input logic rest,
                                          input logic [WATER_W-1:0] water);
    plan_row_t r;
    r = item_row(kind, t, h, s, m);
    r.typed           = 1'b1;
    r.want.pump_on    = pump;
    r.want.resting    = rest;
    r.want.water_used = water;
    return r;
  endfunction

  function automatic plan_row_t cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    plan_row_t r;
    r = item_row(KIND_TICK, '0, '0, '0, 1'b0);
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  // Mostly ticks and automatic evaluations, some manual switching
  function automatic ipc_item_t rand_item();
    ipc_item_t   it;
    int unsigned pick;
    pick           = $urandom_range(0, 99);
    it.temperature = TEMP_W'($urandom_range(0, 255));
    it.humidity    = HUM_W'($urandom_range(0, 255));
    it.soil_level  = SOIL_W'($urandom_range(0, 127));
    it.kind        = (pick < 55) ? KIND_TICK : KIND_EVAL;
    if (pick < 55)
      it.manual = 1'($urandom_range(0, 1));
    else
      it.manual = (pick >= 90);
    return it;
  endfunction

  // Present one item, wait for the transaction, then book its report
  task automatic send_item(input ipc_item_t it, input bit typed, input ipc_result_t want);
    ipc_result_t got;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {it.manual, it.soil_level, it.humidity, it.temperature};
    s_axis_tuser  <= it.kind;
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    got = predict_report(it);
    reports_due.push_back(typed ? want : got);
  endtask

  // Write one register; valid stays up so back-to-back writes need no extra step
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    case (idx)
      REG_TEMP_THR:  reg_shadow.temp_threshold     = val[TEMP_W-1:0];
      REG_HUM_THR:   reg_shadow.humidity_threshold = val[HUM_W-1:0];
      REG_MOIST_THR: reg_shadow.moisture_threshold = val[SOIL_W-1:0];
      REG_MIN_RUN:   reg_shadow.min_run_seconds    = val;
      REG_MAX_RUN:   reg_shadow.max_run_seconds    = val;
      REG_REST:      reg_shadow.rest_seconds       = val;
      REG_FLOW:      reg_shadow.flow_per_second    = val[FLOW_W-1:0];
      default: ;
    endcase
  endtask

  // Stop sending and wait until the pipeline is empty
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_settings(input logic [TEMP_W-1:0] t, input logic [HUM_W-1:0] h,
                               input logic [SOIL_W-1:0] m, input logic [SECS_W-1:0] mn,
                               input logic [SECS_W-1:0] mx, input logic [SECS_W-1:0] rs,
                               input logic [FLOW_W-1:0] f);
    drain_results();
    cfg_write(REG_TEMP_THR, CFG_DATA_W'(t));
    cfg_write(REG_HUM_THR, CFG_DATA_W'(h));
    cfg_write(REG_MOIST_THR, CFG_DATA_W'(m));
    cfg_write(REG_MIN_RUN, mn);
    cfg_write(REG_MAX_RUN, mx);
    cfg_write(REG_REST, rs);
    cfg_write(REG_FLOW, CFG_DATA_W'(f));
    cfg_valid <= 1'b0;
  endtask

  // Receiver: ready, with random stall bursts while idle insertion is on
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left    <= $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic void flag_mismatch(input string what, input logic [WATER_W-1:0] want,
                                        input logic [WATER_W-1:0] seen);
    // keep the log short on a badly broken block
    if (err_count < MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, seen);
    err_count++;
  endfunction

  // Compare each result transaction with the oldest expected report
  always @(posedge clk) begin
    ipc_result_t seen;
    ipc_result_t due;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      seen.pump_on    = m_axis_tdata[0];
      seen.resting    = m_axis_tdata[1];
      seen.water_used = m_axis_tdata[WATER_W+1:2];
      if (reports_due.size() == 0) begin
        if (err_count < MAX_REPORTS)
          $display("%0t: unexpected result: expected none, got pump %0b rest %0b water %0d",
                   $time, seen.pump_on, seen.resting, seen.water_used);
        err_count++;
      end else begin
        due = reports_due.pop_front();
        if (seen.pump_on != due.pump_on)
          flag_mismatch("pump_on", WATER_W'(due.pump_on), WATER_W'(seen.pump_on));
        if (seen.resting != due.resting)
          flag_mismatch("resting", WATER_W'(due.resting), WATER_W'(seen.resting));
        if (seen.water_used != due.water_used)
          flag_mismatch("water_used", due.water_used, seen.water_used);
      end
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    bit in_cfg;
    in_cfg     = 1'b0;
    reg_shadow = '{TEMP_THR_RST, HUM_THR_RST, MOIST_THR_RST, MIN_RUN_RST, MAX_RUN_RST,
                   REST_RST, FLOW_RST};
    pump_state = '0;
    pump_state.minimum_pending = 1'b1;

    // reset settings: idle behavior, thresholds exactly at the edge, a first run
    plan.push_back(typed_row(KIND_TICK, 8'd0, 8'd0, 7'd0, 1'b0, 1'b0, 1'b0, 32'd0));
    plan.push_back(typed_row(KIND_EVAL, 8'd0, 8'd0, 7'd0, 1'b1, 1'b0, 1'b0, 32'd0));
    plan.push_back(typed_row(KIND_EVAL, 8'd30, 8'd20, 7'd35, 1'b0, 1'b0, 1'b0, 32'd0));
    plan.push_back(typed_row(KIND_EVAL, 8'd255, 8'd255, 7'd100, 1'b0, 1'b1, 1'b0, 32'd0));
    plan.push_back(item_row(KIND_TICK, 8'd255, 8'd255, 7'd127, 1'b1));
    // no need, soil out of range, but the minimum still holds the pump on
    plan.push_back(item_row(KIND_EVAL, 8'd0, 8'd255, 7'd127, 1'b0));
    // manual stop of a running pump
    plan.push_back(item_row(KIND_EVAL, 8'd255, 8'd255, 7'd127, 1'b1));
    // short runs, zero rest, full flow; the spare index must be dropped
    plan.push_back(cfg_row(REG_MIN_RUN, 16'd0));
    plan.push_back(cfg_row(REG_MAX_RUN, 16'd1));
    plan.push_back(cfg_row(REG_REST, 16'd0));
    plan.push_back(cfg_row(REG_FLOW, 16'd255));
    plan.push_back(cfg_row(REG_SPARE, 16'hFFFF));
    plan.push_back(item_row(KIND_EVAL, 8'd0, 8'd0, 7'd100, 1'b0));
    plan.push_back(item_row(KIND_TICK, 8'd0, 8'd0, 7'd0, 1'b0));
    plan.push_back(item_row(KIND_TICK, 8'd0, 8'd0, 7'd0, 1'b0));
    // limit reached: stop and rest, then an evaluation while resting
    plan.push_back(item_row(KIND_EVAL, 8'd0, 8'd255, 7'd0, 1'b0));
    plan.push_back(item_row(KIND_EVAL, 8'd255, 8'd0, 7'd0, 1'b0));
    // zero rest ends on the first tick; the next tick finds the timer off
    plan.push_back(item_row(KIND_TICK, 8'd0, 8'd0, 7'd0, 1'b0));
    plan.push_back(item_row(KIND_TICK, 8'd0, 8'd0, 7'd0, 1'b0));
    plan.push_back(cfg_row(REG_REST, 16'd3));
    plan.push_back(cfg_row(REG_FLOW, 16'd0));
    plan.push_back(typed_row(KIND_EVAL, 8'd31, 8'd20, 7'd35, 1'b0, 1'b1, 1'b0, 32'd0));
    plan.push_back(item_row(KIND_TICK, 8'd0, 8'd0, 7'd0, 1'b0));
    plan.push_back(item_row(KIND_TICK, 8'd0, 8'd0, 7'd0, 1'b0));
    plan.push_back(item_row(KIND_EVAL, 8'd255, 8'd255, 7'd100, 1'b0));
    // manual while resting: rest flag drops, the rest timer keeps counting
    plan.push_back(item_row(KIND_EVAL, 8'd0, 8'd0, 7'd0, 1'b1));
    plan.push_back(item_row(KIND_EVAL, 8'd255, 8'd0, 7'd0, 1'b0));
    plan.push_back(item_row(KIND_TICK, 8'd0, 8'd0, 7'd0, 1'b0));
    plan.push_back(item_row(KIND_TICK, 8'd0, 8'd0, 7'd0, 1'b0));
    plan.push_back(item_row(KIND_TICK, 8'd0, 8'd0, 7'd0, 1'b0));
    plan.push_back(item_row(KIND_EVAL, 8'd255, 8'd0, 7'd0, 1'b0));

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // walk the directed table; register writes wait for an empty pipeline
    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        if (!in_cfg) begin
          drain_results();
          in_cfg = 1'b1;
        end
        cfg_write(plan[i].idx, plan[i].val);
      end else begin
        if (in_cfg) begin
          cfg_valid <= 1'b0;
          in_cfg = 1'b0;
        end
        send_item(plan[i].item, plan[i].typed, plan[i].want);
      end
    end

    // random phases, each under its own register settings
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: load_settings(8'd0, 8'd255, 7'd100, 16'd0, 16'd0, 16'd0, 8'd255);
        1: load_settings(8'd255, 8'd0, 7'd100, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd1);
        default: load_settings(TEMP_W'($urandom_range(0, 255)),
                               HUM_W'($urandom_range(0, 255)),
                               (p == 2) ? 7'd0 : 7'($urandom_range(0, 100)),
                               SECS_W'($urandom_range(0, 6)),
                               SECS_W'($urandom_range(0, 12)),
                               SECS_W'($urandom_range(0, 8)),
                               FLOW_W'($urandom_range(0, 255)));
      endcase
      if (p == NUM_PHASES - 1)
        idle_on = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // hold the sender once until every report is back
        if (p == 3 && n == PHASE_ITEMS / 2)
          drain_results();
        send_item(rand_item(), 1'b0, '0);
      end
    end

    drain_results();
    if (err_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
